@@ hw/rtl/well512_pkg.sv @@
// ----------------------------------------------------------------------------
// well512_pkg
// Shared types and constants for the WELL512 generator.
// ----------------------------------------------------------------------------
package well512_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned POOL_LEN = 16;

    localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;

    // request codes on the cmd port
    localparam logic [1:0] CMD_RAW    = 2'd0;
    localparam logic [1:0] CMD_RANGE  = 2'd1;
    localparam logic [1:0] CMD_SIGNED = 2'd2;

    typedef enum logic [1:0] {
        OP_RAW,
        OP_RANGE,
        OP_SIGNED
    } op_t;

    // classified request, as held in the queue
    typedef struct packed {
        op_t               op;
        logic              span_zero;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] low;
    } req_t;

endpackage

@@ hw/rtl/well512_front.sv @@
// ----------------------------------------------------------------------------
// well512_front
// Takes request items, decodes cmd and works out the range span.
// ----------------------------------------------------------------------------
module well512_front
    import well512_pkg::*;
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [WORD_W-1:0] range_low,
    input  logic [WORD_W-1:0] range_high,
    input  logic              fill_busy,
    input  logic              q_full,
    output logic              push,
    output req_t              push_item
);

    logic [WORD_W-1:0] span;
    op_t               op;

    // span wraps mod 2^32; zero span means "take the word unreduced" (low is still added)
    assign span = range_high - range_low + 32'd1;

    always_comb
    begin
        case (cmd)
            CMD_RANGE:  op = OP_RANGE;
            CMD_SIGNED: op = OP_SIGNED;
            CMD_RAW:    op = OP_RAW;
            default:    op = OP_RAW;   // unused code behaves as raw
        endcase
    end

    assign in_ready            = !q_full && !fill_busy;
    assign push                = in_valid && in_ready;
    assign push_item.op        = op;
    assign push_item.span_zero = (span == '0);
    assign push_item.span      = span;
    assign push_item.low       = range_low;

endmodule

@@ hw/rtl/well512_queue.sv @@
// ----------------------------------------------------------------------------
// well512_queue
// Small FIFO of decoded requests between front and back.
// ----------------------------------------------------------------------------
module well512_queue
    import well512_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_item,
    input  logic pop,
    output req_t pop_item,
    output logic empty,
    output logic full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    req_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

@@ hw/rtl/well512_back.sv @@
// ----------------------------------------------------------------------------
// well512_back
// Pool, seed fill, WELL512 draw, bit-serial modulo and result register.
// ----------------------------------------------------------------------------
module well512_back
    import well512_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [WORD_W-1:0] cfg_wr_data,
    input  logic              q_empty,
    input  req_t              q_item,
    output logic              q_pop,
    output logic              fill_busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value
);

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_DRAW2,
        ST_DIV
    } state_t;

    localparam int unsigned FILL_W = $clog2(POOL_LEN);
    localparam int unsigned DIV_W  = $clog2(WORD_W);

    // pool kept rotated: word i of the array is pool[(position + i) mod 16]
    logic [WORD_W-1:0] pool_reg [POOL_LEN];
    logic [WORD_W-1:0] pool_next [POOL_LEN];

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] seed_prev_reg, seed_prev_next;
    logic [FILL_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [DIV_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] span_reg, span_next;
    logic [WORD_W-1:0] low_reg, low_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] value_reg, value_next;

    // draw datapath
    logic [WORD_W-1:0] w0, w9, w13, w15;
    logic [WORD_W-1:0] mix, shifted, fresh, tempered, drawn;

    // fill datapath
    logic [WORD_W-1:0] seed_mixed, seed_prod;

    // divider step
    logic [WORD_W:0]   div_trial;
    logic              div_ge;
    logic [WORD_W-1:0] rem_step;

    logic              draw_en;

    assign w0  = pool_reg[0];
    assign w9  = pool_reg[9];
    assign w13 = pool_reg[13];
    assign w15 = pool_reg[15];

    assign mix      = w0 ^ w13 ^ (w0 << 16) ^ (w13 << 15);
    assign shifted  = w9 ^ (w9 >> 11);
    assign fresh    = mix ^ shifted;
    assign tempered = fresh ^ ((fresh << 5) & TEMPER_MASK);
    assign drawn    = w15 ^ mix ^ tempered ^ (w15 << 2) ^ (mix << 18) ^ (shifted << 28);

    assign seed_mixed = seed_prev_reg ^ (seed_prev_reg >> 30);
    assign seed_prod  = seed_mixed * SEED_MULT;

    assign div_trial = {rem_reg, quo_reg[WORD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, span_reg});
    assign rem_step  = div_ge ? WORD_W'(div_trial - {1'b0, span_reg})
                              : div_trial[WORD_W-1:0];

    assign q_pop = (state_reg == ST_IDLE) && !q_empty && (!out_valid_reg || out_ready);
    assign draw_en = q_pop || (state_reg == ST_DRAW2);

    assign fill_busy = (state_reg == ST_FILL);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    always_comb
    begin
        state_next     = state_reg;
        seed_prev_next = seed_prev_reg;
        fill_cnt_next  = fill_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        span_next      = span_reg;
        low_next       = low_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pool_next      = pool_reg;

        if (draw_en)
        begin
            // one WELL512 step; position moves back by one
            pool_next[0] = drawn;
            pool_next[1] = fresh;
            for (int i = 2; i < POOL_LEN; i++)
                pool_next[i] = pool_reg[i-1];
        end

        case (state_reg)
            ST_FILL:
            begin
                for (int i = 0; i < POOL_LEN - 1; i++)
                    pool_next[i] = pool_reg[i+1];
                pool_next[POOL_LEN-1] = seed_prev_reg;
                seed_prev_next = seed_prod + WORD_W'(fill_cnt_reg) + WORD_W'(1);
                fill_cnt_next  = fill_cnt_reg + FILL_W'(1);
                if (fill_cnt_reg == FILL_W'(POOL_LEN - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_item.op)
                        OP_RANGE:
                        begin
                            if (q_item.span_zero)
                            begin
                                value_next     = drawn + q_item.low;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                quo_next     = drawn;
                                rem_next     = '0;
                                span_next    = q_item.span;
                                low_next     = q_item.low;
                                div_cnt_next = '0;
                                state_next   = ST_DIV;
                            end
                        end
                        OP_SIGNED:
                        begin
                            low_next   = {{(WORD_W-1){1'b0}}, drawn[0]};
                            state_next = ST_DRAW2;
                        end
                        default:
                        begin
                            value_next     = drawn;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAW2:
            begin
                value_next     = low_reg[0] ? drawn : (WORD_W'(0) - drawn);
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_DIV:
            begin
                rem_next     = rem_step;
                quo_next     = quo_reg << 1;
                div_cnt_next = div_cnt_reg + DIV_W'(1);
                if (div_cnt_reg == DIV_W'(WORD_W - 1))
                begin
                    value_next     = rem_step + low_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // seed write restarts the fill
        if (cfg_wr_en)
        begin
            state_next     = ST_FILL;
            seed_prev_next = cfg_wr_data;
            fill_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            seed_prev_reg <= '0;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_prev_reg <= seed_prev_next;
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pool_reg    <= pool_next;
        div_cnt_reg <= div_cnt_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        span_reg    <= span_next;
        low_reg     <= low_next;
        value_reg   <= value_next;
    end

endmodule

@@ hw/rtl/well512_random_generator_top.sv @@
// ----------------------------------------------------------------------------
// well512_random_generator_top
// WELL512 random generator with raw, range and signed request items.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready, cmd, range_low, range_high) takes one
//   item per request; result channel (out_valid/out_ready, value) gives one
//   32-bit item per request, in request order.
//   cfg_wr_en/cfg_wr_data write the seed; the pool is refilled and the
//   position cleared. Write only while the block is idle.
// Result path: raw takes one draw, signed two draws, range one draw and
//   then the 32-step bit-serial modulo in the back end. A zero span skips
//   the divider. The back end takes one request per run: it pops the next
//   one only while idle, with the result register free.
// Reset and seed writes: the pool is filled one word a cycle, during which
//   in_ready is low. After reset the fill uses seed 0.
// Receiver stall: the result register holds; the queue keeps taking requests
//   until full, then in_ready drops.
// ----------------------------------------------------------------------------
module well512_random_generator_top
    import well512_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [WORD_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [WORD_W-1:0] range_low,
    input  logic [WORD_W-1:0] range_high,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] value
);

    logic push, pop, q_empty, q_full, fill_busy;
    req_t push_item, pop_item;

    // front end: decode and span
    well512_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .range_low  (range_low),
        .range_high (range_high),
        .fill_busy  (fill_busy),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    // decouples request side from the long-running back end
    well512_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    // back end: pool, draws, modulo, result register
    well512_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_item      (pop_item),
        .q_pop       (pop),
        .fill_busy   (fill_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value)
    );

endmodule

@@ hw/rtl/well512_checker.sv @@
// ----------------------------------------------------------------------------
// well512_checker
// Port-level checks on the generator, bound to the top level.
// ----------------------------------------------------------------------------
module well512_checker
    import well512_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_wr_en,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        cmd,
    input logic [WORD_W-1:0] range_low,
    input logic [WORD_W-1:0] range_high,
    input logic              out_valid,
    input logic              out_ready,
    input logic [WORD_W-1:0] value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("result dropped or changed under stall");

    // waiting request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable({cmd, range_low, range_high}))
        else $error("request dropped or changed while waiting");

    // seed write starts the refill at once
    a_fill_start: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !in_ready)
        else $error("request taken right after seed write");

    // refill lasts the whole pool
    a_fill_len: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> ##16 !in_ready)
        else $error("request taken before pool refill finished");

endmodule

bind well512_random_generator_top well512_checker u_checker (.*);

@@ test/well512_random_generator_top_test.sv @@
// ----------------------------------------------------------------------------
// well512_random_generator_top_test
// Self-checking bench for the WELL512 generator: a local copy of the pool and
// position predicts every result, which is compared against the block's
// output item by item under random idling, back-pressure and reseeding.
// ----------------------------------------------------------------------------
module well512_random_generator_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import well512_pkg::*;

    // cmd 3 is unused by the block; it behaves as a raw draw
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no handshake or seed write
    localparam int HOLD_OFF_LEN   = 300;    // long receiver stall
    localparam int SETTLE_CYCLES  = 40;     // wait after the last result; range is the slowest request
    localparam int REPORT_LIMIT   = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [WORD_W-1:0] cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        cmd = CMD_RAW;
    logic [WORD_W-1:0] range_low = '0;
    logic [WORD_W-1:0] range_high = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [WORD_W-1:0] value;

    // local copy of the generator state
    logic [WORD_W-1:0] pool_words [POOL_LEN];
    logic [3:0]        pool_pos;

    logic [WORD_W-1:0] awaited_values [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_request = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    well512_random_generator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .range_low   (range_low),
        .range_high  (range_high),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Seed fill: multiplicative recurrence, position back to zero.
    function automatic void reseed_pool(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] prev;
        pool_words[0] = seed;
        for (int k = 1; k < POOL_LEN; k++)
        begin
            prev = pool_words[k-1];
            pool_words[k] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(k);
        end
        pool_pos = '0;
    endfunction

    // One WELL512 step; returns the word written at the new position.
    function automatic logic [WORD_W-1:0] draw_pool_word();
        logic [3:0]        p;
        logic [WORD_W-1:0] w0, w13, w9, mix, shifted, fresh, tempered, prev;
        p        = pool_pos;
        w0       = pool_words[p];
        w13      = pool_words[p + 4'd13];
        mix      = w0 ^ w13 ^ (w0 << 16) ^ (w13 << 15);
        w9       = pool_words[p + 4'd9];
        shifted  = w9 ^ (w9 >> 11);
        fresh    = mix ^ shifted;
        pool_words[p] = fresh;
        tempered = fresh ^ ((fresh << 5) & TEMPER_MASK);
        p        = p + 4'd15;
        pool_pos = p;
        prev     = pool_words[p];
        pool_words[p] = prev ^ mix ^ tempered ^ (prev << 2) ^ (mix << 18)
                        ^ (shifted << 28);
        return pool_words[p];
    endfunction

    function automatic logic [WORD_W-1:0] request_result(input logic [1:0] c,
                                                         input logic [WORD_W-1:0] lo,
                                                         input logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] w, span, first, second;
        case (c)
            CMD_RANGE:
            begin
                w    = draw_pool_word();
                span = hi - lo + 1'b1;
                // a span that wraps to zero passes the word through unreduced
                return ((span == '0) ? w : (w % span)) + lo;
            end
            CMD_SIGNED:
            begin
                first  = draw_pool_word();
                second = draw_pool_word();
                return first[0] ? second : (~second + 1'b1);
            end
            default:
                return draw_pool_word();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: every accepted output item against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [WORD_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_values.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result %08h with no request outstanding", $realtime, value);
            end
            else
            begin
                want = awaited_values.pop_front();
                if (value !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: value mismatch, expected %08h, got %08h",
                                 $realtime, want, value);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random idling, or a long hold-off counted here on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int stretch;
        forever
        begin
            @(posedge clk);
            if (hold_off_request != 0)
            begin
                stretch = hold_off_request;
                hold_off_request = 0;
                out_ready <= 1'b0;
                repeat (stretch) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if neither channel nor the seed port moves
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("well512_random_generator_top_test: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------

    // Offer one request item; the prediction is queued at the accepting edge.
    task automatic send_request(input logic [1:0] c,
                                input logic [WORD_W-1:0] lo,
                                input logic [WORD_W-1:0] hi);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        range_low  <= lo;
        range_high <= hi;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_values.push_back(request_result(c, lo, hi));
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic wait_results();
        in_valid <= 1'b0;
        while (awaited_values.size() != 0)
            @(posedge clk);
    endtask

    // Seed write, only with the block idle (nothing outstanding, fill finished).
    task automatic load_seed(input logic [WORD_W-1:0] seed);
        wait_results();
        while (!in_ready)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        reseed_pool(seed);
    endtask

    function automatic logic [1:0] pick_cmd();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return CMD_RAW;
        else if (roll < 65)
            return CMD_RANGE;
        else if (roll < 95)
            return CMD_SIGNED;
        return CMD_SPARE;
    endfunction

    // Range bounds: many narrow spans, plus random, wrap, zero-span and edge values.
    task automatic pick_bounds(output logic [WORD_W-1:0] lo, output logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] edges [4];
        edges = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        lo = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: hi = lo + $urandom_range(0, 100);
            4, 5:       hi = $urandom;
            6:
            begin
                lo = '0;
                hi = $urandom;
            end
            7:
            begin
                lo = edges[$urandom_range(3)];
                hi = edges[$urandom_range(3)];
            end
            8:          hi = lo - 1'b1;              // span wraps to zero
            default:    hi = lo - $urandom_range(1, 50);  // low above high
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Draws straight after reset come from the seed-0 fill.
    task automatic test_reset_fill();
        send_request(CMD_RAW, '0, '0);
        send_request(CMD_RAW, '1, '1);
        send_request(CMD_SIGNED, '0, '1);
        send_request(CMD_RAW, '0, '0);
        wait_results();
    endtask

    // Seed register at both ends of its range.
    task automatic test_seed_extremes();
        load_seed(32'h0000_0000);
        repeat (3) send_request(CMD_RAW, '0, '0);
        load_seed(32'hFFFF_FFFF);
        repeat (3) send_request(CMD_RAW, '1, '1);
        send_request(CMD_RANGE, 32'd0, 32'd9);
        wait_results();
    endtask

    // Every request code and the corner cases of range mode.
    task automatic test_directed_cases();
        load_seed(32'h1234_5678);
        send_request(CMD_RAW,    32'h0000_0000, 32'h0000_0000);
        send_request(CMD_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // full span: wraps to zero, word passes through
        send_request(CMD_RANGE,  32'h0000_0000, 32'hFFFF_FFFF);
        // zero span with a non-zero low bound still adds the low bound
        send_request(CMD_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(CMD_RANGE,  32'h8000_0000, 32'h7FFF_FFFF);
        // single-value ranges
        send_request(CMD_RANGE,  32'h0000_0000, 32'h0000_0000);
        send_request(CMD_RANGE,  32'h0000_0007, 32'h0000_0007);
        send_request(CMD_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // low above high: no check, arithmetic wraps
        send_request(CMD_RANGE,  32'h0000_000A, 32'h0000_0003);
        send_request(CMD_RANGE,  32'hFFFF_FFF0, 32'h0000_0010);
        send_request(CMD_RANGE,  32'h0000_0000, 32'h0000_0001);
        send_request(CMD_RANGE,  32'h0000_0000, 32'hFFFF_FFFE);
        send_request(CMD_RANGE,  32'd100,       32'd1099);
        // signed: several draws so both sign choices appear
        repeat (6) send_request(CMD_SIGNED, $urandom, $urandom);
        // unused selector behaves as raw
        send_request(CMD_SPARE,  32'hFFFF_FFFF, 32'h0000_0000);
        send_request(CMD_SPARE,  32'h0000_0000, 32'hFFFF_FFFF);
        wait_results();
    endtask

    // Random traffic under one idling profile, with the odd full drain.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int item_count, input logic [WORD_W-1:0] seed);
        logic [1:0]        c;
        logic [WORD_W-1:0] lo, hi;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        load_seed(seed);
        for (int n = 0; n < item_count; n++)
        begin
            c = pick_cmd();
            pick_bounds(lo, hi);
            send_request(c, lo, hi);
            if ($urandom_range(39) == 0)
                wait_results();
        end
        wait_results();
    endtask

    // Receiver stalls for a long stretch while requests keep coming, so the
    // queue fills and in_ready drops; then everything must drain in order.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_seed(32'h8000_0000);
        hold_off_request = HOLD_OFF_LEN;
        repeat (8) send_request(CMD_RAW, $urandom, $urandom);
        repeat (2) send_request(CMD_SIGNED, $urandom, $urandom);
        send_request(CMD_RANGE, 32'd0, 32'd999);
        send_request(CMD_RAW, $urandom, $urandom);
        wait_results();
    endtask

    initial
    begin
        reseed_pool('0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_fill();
        test_seed_extremes();
        test_directed_cases();
        test_random_traffic(27, 72, 120, $urandom);
        test_random_traffic(72, 27, 120, 32'h0000_0001);
        test_random_traffic(0, 0, 120, $urandom);
        test_back_pressure();

        wait_results();
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_values.size() == 0)
            $display("well512_random_generator_top_test: done, clean");
        else
            $display("well512_random_generator_top_test: done, errors");
        $finish;
    end

endmodule
